// ----- rtl/pps_pkg.sv -----
package pps_pkg;

    localparam int unsigned POOL_SLOTS = 8;
    localparam int unsigned KEY_BITS   = 16;
    localparam int unsigned PIN_BITS   = 8;

    localparam int unsigned IDX_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int unsigned CNT_W = $clog2(POOL_SLOTS + 1);

    localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

    typedef enum logic [2:0] {
        ST_HIT     = 3'd0,
        ST_LOADED  = 3'd1,
        ST_FULL    = 3'd2,
        ST_HELD    = 3'd3,
        ST_FREED   = 3'd4,
        ST_MISSING = 3'd5,
        ST_INVALID = 3'd6
    } status_t;

    // search token rippling down the slot chain
    typedef struct packed {
        logic                live;
        logic                hit;
        logic [IDX_W-1:0]    hit_idx;
        logic [PIN_BITS-1:0] hit_pins;
        logic                free;
        logic [IDX_W-1:0]    free_idx;
    } token_t;

    // slot update broadcast from the controller
    typedef struct packed {
        logic                wr;
        logic [IDX_W-1:0]    idx;
        logic                valid;
        logic                key_wr;
        logic [PIN_BITS-1:0] pins;
    } cmd_t;

endpackage

// ----- rtl/pps_cell.sv -----
module pps_cell
    import pps_pkg::*;
#(
    parameter int unsigned SLOT_ID = 0
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [KEY_BITS-1:0] search_key,
    input  token_t              tok_in,
    output token_t              tok_out,
    input  cmd_t                cmd
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(SLOT_ID);

    logic                valid_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [PIN_BITS-1:0] pins_reg;
    token_t              tok_reg;
    token_t              tok_next;
    logic                sel;

    assign sel = cmd.wr && (cmd.idx == MY_IDX);

    // add this slot's view to the passing token, first match and first free win
    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.live && valid_reg && (key_reg == search_key) && !tok_in.hit)
        begin
            tok_next.hit      = 1'b1;
            tok_next.hit_idx  = MY_IDX;
            tok_next.hit_pins = pins_reg;
        end
        if (tok_in.live && !valid_reg && !tok_in.free)
        begin
            tok_next.free     = 1'b1;
            tok_next.free_idx = MY_IDX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pins_reg  <= '0;
            tok_reg   <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (sel)
            begin
                valid_reg <= cmd.valid;
                pins_reg  <= cmd.pins;
            end
        end
    end

    // key is payload, written only on a fill
    always_ff @(posedge clk)
    begin
        if (sel && cmd.key_wr)
        begin
            key_reg <= search_key;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ----- rtl/pinned_slot_pool_top.sv -----
// a valid key's token is launched from the request register and passes every slot cell register
//   before its result is registered; an invalid key gives its result on the cycle after its transfer in
// one request at a time: no new request is taken until the result has been taken; the search
//   token walks the slot chain one cell a cycle
// reset: rst_n async active low; all slots free, counters zero, key_limit 1024
module pinned_slot_pool_top
    import pps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // operation[0], account_key[16:1], zero pad

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,   // status[2:0], slot_index[5:3], pins_after[13:6],
                                        // slots_in_use[17:14], loads_total[49:18],
                                        // unloads_total[81:50], zero pad

    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data     // key_limit
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_OUT
    } state_t;

    state_t              state_reg;
    logic                op_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [15:0]         key_limit_reg;
    logic                launch_reg;
    logic [CNT_W-1:0]    in_use_reg;
    logic [31:0]         loads_reg;
    logic [31:0]         unloads_reg;

    // result register
    logic                out_valid_reg;
    status_t             out_status_reg;
    logic [IDX_W-1:0]    out_idx_reg;
    logic [PIN_BITS-1:0] out_pins_reg;

    // decision from the token at the chain end
    token_t              tok_chain [POOL_SLOTS+1];
    token_t              tok_end;
    cmd_t                cmd;
    status_t             dec_status;
    logic [IDX_W-1:0]    dec_idx;
    logic [PIN_BITS-1:0] dec_pins;
    logic [CNT_W-1:0]    in_use_next;
    logic [31:0]         loads_next;
    logic [31:0]         unloads_next;
    logic [PIN_BITS-1:0] pins_dec;

    logic                in_xfer;
    logic                out_xfer;
    logic                in_op;
    logic [15:0]         in_raw;
    logic                in_bad;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_xfer      = out_valid_reg && m_axis_tready;
    assign in_op         = s_axis_tdata[0];
    assign in_raw        = s_axis_tdata[16:1];
    assign in_bad        = (in_raw >= key_limit_reg);

    // token enters cell 0 from launch_reg, which is registered together with the request
    assign tok_chain[0] = '{live: launch_reg, default: '0};

    for (genvar i = 0; i < POOL_SLOTS; i++)
    begin : g_cell
        pps_cell #(
            .SLOT_ID (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .search_key (key_reg),
            .tok_in     (tok_chain[i]),
            .tok_out    (tok_chain[i+1]),
            .cmd        (cmd)
        );
    end

    assign tok_end  = tok_chain[POOL_SLOTS];
    // an unpinned valid slot is freed without wrapping its count
    assign pins_dec = (tok_end.hit_pins != '0) ? (tok_end.hit_pins - 1'b1) : '0;

    always_comb
    begin
        cmd          = '0;
        dec_status   = ST_MISSING;
        dec_idx      = '0;
        dec_pins     = '0;
        in_use_next  = in_use_reg;
        loads_next   = loads_reg;
        unloads_next = unloads_reg;
        if (!op_reg)
        begin
            if (tok_end.hit)
            begin
                // pin count saturates
                cmd.wr     = 1'b1;
                cmd.idx    = tok_end.hit_idx;
                cmd.valid  = 1'b1;
                cmd.pins   = (tok_end.hit_pins == PIN_MAX) ? PIN_MAX
                                                           : (tok_end.hit_pins + 1'b1);
                dec_status = ST_HIT;
                dec_idx    = tok_end.hit_idx;
                dec_pins   = cmd.pins;
            end
            else if (tok_end.free)
            begin
                cmd.wr      = 1'b1;
                cmd.idx     = tok_end.free_idx;
                cmd.valid   = 1'b1;
                cmd.key_wr  = 1'b1;
                cmd.pins    = PIN_BITS'(1);
                dec_status  = ST_LOADED;
                dec_idx     = tok_end.free_idx;
                dec_pins    = PIN_BITS'(1);
                in_use_next = in_use_reg + 1'b1;
                loads_next  = loads_reg + 32'd1;
            end
            else
            begin
                dec_status = ST_FULL;
            end
        end
        else
        begin
            if (tok_end.hit)
            begin
                cmd.wr  = 1'b1;
                cmd.idx = tok_end.hit_idx;
                dec_idx = tok_end.hit_idx;
                if (pins_dec == '0)
                begin
                    cmd.valid    = 1'b0;
                    cmd.pins     = '0;
                    dec_status   = ST_FREED;
                    in_use_next  = in_use_reg - 1'b1;
                    unloads_next = unloads_reg + 32'd1;
                end
                else
                begin
                    cmd.valid  = 1'b1;
                    cmd.pins   = pins_dec;
                    dec_status = ST_HELD;
                    dec_pins   = pins_dec;
                end
            end
            else
            begin
                dec_status = ST_MISSING;
            end
        end
        // slots change only as the token leaves the chain
        if (!((state_reg == S_SEARCH) && tok_end.live))
        begin
            cmd.wr = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= 1'b0;
            key_reg        <= '0;
            key_limit_reg  <= 16'd1024;
            launch_reg     <= 1'b0;
            in_use_reg     <= '0;
            loads_reg      <= '0;
            unloads_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_HIT;
            out_idx_reg    <= '0;
            out_pins_reg   <= '0;
        end
        else
        begin
            launch_reg <= 1'b0;
            if (cfg_wr_en)
            begin
                key_limit_reg <= cfg_wr_data;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        op_reg  <= in_op;
                        key_reg <= KEY_BITS'(in_raw);
                        if (in_bad)
                        begin
                            // invalid key changes nothing
                            out_valid_reg  <= 1'b1;
                            out_status_reg <= ST_INVALID;
                            out_idx_reg    <= '0;
                            out_pins_reg   <= '0;
                            state_reg      <= S_OUT;
                        end
                        else
                        begin
                            launch_reg <= 1'b1;
                            state_reg  <= S_SEARCH;
                        end
                    end
                end
                S_SEARCH:
                begin
                    if (tok_end.live)
                    begin
                        in_use_reg     <= in_use_next;
                        loads_reg      <= loads_next;
                        unloads_reg    <= unloads_next;
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= dec_status;
                        out_idx_reg    <= dec_idx;
                        out_pins_reg   <= dec_pins;
                        state_reg      <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_xfer)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid       = out_valid_reg;
    assign m_axis_tdata[2:0]   = out_status_reg;
    assign m_axis_tdata[5:3]   = 3'(out_idx_reg);
    assign m_axis_tdata[13:6]  = 8'(out_pins_reg);
    assign m_axis_tdata[17:14] = 4'(in_use_reg);
    assign m_axis_tdata[49:18] = loads_reg;
    assign m_axis_tdata[81:50] = unloads_reg;
    assign m_axis_tdata[87:82] = '0;

endmodule

// ----- rtl/pps_check.sv -----
module pps_check
    import pps_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [23:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [87:0] m_axis_tdata,
    input logic        cfg_wr_en,
    input logic [15:0] cfg_wr_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one request at a time: no intake while a result waits
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while result pending");

    // a transfer in makes the block busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready stayed high after transfer");

    // untouched-slot statuses report zero pins, no slot
    a_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[2:0] == ST_FULL || m_axis_tdata[2:0] == ST_MISSING
                          || m_axis_tdata[2:0] == ST_INVALID)
        |-> (m_axis_tdata[5:3] == 3'd0) && (m_axis_tdata[13:6] == 8'd0))
        else $error("slot fields set without a slot");

    // usage count within the pool
    a_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (32'(m_axis_tdata[17:14]) <= POOL_SLOTS))
        else $error("slots in use exceeds pool size");

endmodule

bind pinned_slot_pool_top pps_check u_pps_check (.*);

// ----- dv/tb.sv -----
module tb;
    import pps_pkg::*;

    // request operation codes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_UNLOAD = 1'b1;

    // run guard, generous against the slowest correct run
    localparam int CYCLE_LIMIT  = 500000;
    // quiet time after the last result
    localparam int DRAIN_CYCLES = 2 * POOL_SLOTS + 8;
    // keys drawn again and again so that hits, fills and full answers happen
    localparam int HOT_KEYS     = 12;

    typedef struct packed {
        logic        op;
        logic [15:0] key;
    } pool_req_t;

    typedef struct {
        status_t     status;
        logic [2:0]  slot;
        logic [7:0]  pins;
        logic [3:0]  in_use;
        logic [31:0] loads;
        logic [31:0] unloads;
    } pool_resp_t;

    // every block input is known from time zero
    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;     // operation[0], account_key[16:1], zero pad
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;           // status[2:0], slot_index[5:3], pins_after[13:6],
                                         // slots_in_use[17:14], loads_total[49:18],
                                         // unloads_total[81:50], zero pad
    logic        cfg_wr_en     = 1'b0;
    logic [15:0] cfg_wr_data   = '0;     // key_limit

    // our own copy of the pool and its register
    logic [15:0]         model_limit;
    logic                model_valid [POOL_SLOTS];
    logic [KEY_BITS-1:0] model_key   [POOL_SLOTS];
    logic [PIN_BITS-1:0] model_pins  [POOL_SLOTS];
    logic [31:0]         model_loads;
    logic [31:0]         model_unloads;

    // requests waiting to be offered, and answers waiting to come back
    pool_req_t  requests_pending[$];
    pool_resp_t pool_results_due[$];
    pool_req_t  req_on_bus;
    pool_resp_t resp_due;

    logic [15:0] hot_keys [HOT_KEYS];
    int          issued_total  = 0;
    int          results_done  = 0;
    int          errors        = 0;
    int          cycles        = 0;
    // percent chance per cycle that an idle burst starts, 0 turns idling off
    int          gap_pct       = 0;
    int          send_gap_left = 0;
    int          recv_gap_left = 0;

    pinned_slot_pool_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // expected answer to one request; updates the pool copy as the block would
    function automatic pool_resp_t predict_pool_response(pool_req_t req);
        pool_resp_t r;
        int         hit_at;
        int         free_at;
        int         used;
        int         i;
        hit_at  = -1;
        free_at = -1;
        used    = 0;
        r.status = ST_INVALID;
        r.slot   = '0;
        r.pins   = '0;
        // lowest matching slot and lowest free slot, as a priority search would find them
        for (i = 0; i < POOL_SLOTS; i++)
        begin
            if (model_valid[i] && model_key[i] == req.key[KEY_BITS-1:0] && hit_at < 0)
                hit_at = i;
            if (!model_valid[i] && free_at < 0)
                free_at = i;
        end
        if (req.key >= model_limit)
            r.status = ST_INVALID;
        else if (req.op == OP_LOAD)
        begin
            if (hit_at >= 0)
            begin
                // pin count sticks at its maximum
                if (model_pins[hit_at] != PIN_MAX)
                    model_pins[hit_at]++;
                r.status = ST_HIT;
                r.slot   = hit_at[2:0];
                r.pins   = model_pins[hit_at];
            end
            else if (free_at >= 0)
            begin
                model_valid[free_at] = 1'b1;
                model_key[free_at]   = req.key[KEY_BITS-1:0];
                model_pins[free_at]  = PIN_BITS'(1);
                model_loads++;
                r.status = ST_LOADED;
                r.slot   = free_at[2:0];
                r.pins   = 8'd1;
            end
            else
                r.status = ST_FULL;
        end
        else if (hit_at >= 0)
        begin
            if (model_pins[hit_at] != '0)
                model_pins[hit_at]--;
            r.slot = hit_at[2:0];
            if (model_pins[hit_at] == '0)
            begin
                model_valid[hit_at] = 1'b0;
                model_unloads++;
                r.status = ST_FREED;
            end
            else
            begin
                r.status = ST_HELD;
                r.pins   = model_pins[hit_at];
            end
        end
        else
            r.status = ST_MISSING;
        for (i = 0; i < POOL_SLOTS; i++)
            if (model_valid[i])
                used++;
        r.in_use  = used[3:0];
        r.loads   = model_loads;
        r.unloads = model_unloads;
        return r;
    endfunction

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $error("%s: expected %0d, actual %0d", name, want, got);
        end
    endtask

    task automatic queue_request(input logic op, input logic [15:0] key);
        pool_req_t req;
        req.op  = op;
        req.key = key;
        requests_pending.push_back(req);
        issued_total++;
    endtask

    // refill the working set of keys, all of them valid under the current limit unless it is zero
    task automatic pick_hot_keys();
        int i;
        for (i = 0; i < HOT_KEYS; i++)
            if (model_limit == '0)
                hot_keys[i] = 16'($urandom());
            else
                hot_keys[i] = 16'($urandom_range(0, int'(model_limit) - 1));
    endtask

    // mostly working-set keys, some noise and some keys right at the limit
    task automatic queue_mixed(input int n, input int load_pct);
        int          pick;
        logic [15:0] key;
        logic        op;
        repeat (n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
                key = hot_keys[$urandom_range(0, HOT_KEYS - 1)];
            else if (pick < 90)
                key = 16'($urandom());
            else
                key = model_limit - 16'($urandom_range(0, 1));
            op = ($urandom_range(0, 99) < load_pct) ? OP_LOAD : OP_UNLOAD;
            queue_request(op, key);
        end
    endtask

    // sampled on the falling edge so it never races the clocked blocks
    task automatic wait_drained();
        while (results_done != issued_total)
            @(negedge clk);
    endtask

    // only called with the block idle: nothing pending, every answer back
    task automatic set_key_limit(input logic [15:0] limit);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= limit;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        model_limit = limit;
        pick_hot_keys();
        @(negedge clk);
    endtask

    // request driver: a new item goes out once the previous transfer completes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                pool_results_due.push_back(predict_pool_response(req_on_bus));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap_left > 0)
                begin
                    send_gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
                begin
                    // this cycle is the first of an idle gap whose remaining length is drawn into send_gap_left
                    send_gap_left = $urandom_range(0, 18);
                    s_axis_tvalid <= 1'b0;
                end
                else if (requests_pending.size() != 0)
                begin
                    req_on_bus = requests_pending.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {7'b0, req_on_bus.key, req_on_bus.op};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result monitor with random backpressure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pool_results_due.size() == 0)
                begin
                    errors++;
                    $error("result transfer with no request outstanding");
                end
                else
                begin
                    resp_due = pool_results_due.pop_front();
                    results_done++;
                    report_field("status",        32'(resp_due.status),
                                 32'(m_axis_tdata[2:0]));
                    report_field("slot_index",    32'(resp_due.slot),
                                 32'(m_axis_tdata[5:3]));
                    report_field("pins_after",    32'(resp_due.pins),
                                 32'(m_axis_tdata[13:6]));
                    report_field("slots_in_use",  32'(resp_due.in_use),
                                 32'(m_axis_tdata[17:14]));
                    report_field("loads_total",   resp_due.loads,   m_axis_tdata[49:18]);
                    report_field("unloads_total", resp_due.unloads, m_axis_tdata[81:50]);
                end
            end
            if (recv_gap_left > 0)
            begin
                recv_gap_left--;
                m_axis_tready <= 1'b0;
            end
            else if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
            begin
                recv_gap_left = $urandom_range(0, 18);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // hang guard
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        int i;
        // pool copy starts empty, register at its reset value
        model_limit   = 16'd1024;
        model_loads   = '0;
        model_unloads = '0;
        for (i = 0; i < POOL_SLOTS; i++)
        begin
            model_valid[i] = 1'b0;
            model_key[i]   = '0;
            model_pins[i]  = '0;
        end
        pick_hot_keys();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: widest limit, key extremes, every status, fill to full and refill
        gap_pct = 15;
        set_key_limit(16'hFFFF);
        queue_request(OP_UNLOAD, 16'h0000);     // not found on an empty pool
        queue_request(OP_LOAD,   16'h0000);     // first fill takes slot 0
        queue_request(OP_LOAD,   16'hFFFE);     // highest valid key
        queue_request(OP_LOAD,   16'hFFFF);     // never below any limit
        queue_request(OP_UNLOAD, 16'hFFFF);
        queue_request(OP_LOAD,   16'h0000);     // hit raises the pin count
        queue_request(OP_UNLOAD, 16'h0000);     // still held
        queue_request(OP_UNLOAD, 16'h0000);     // freed
        for (i = 0; i < 7; i++)
            queue_request(OP_LOAD, 16'h0100 + 16'(i));
        queue_request(OP_LOAD,   16'h0200);     // every slot taken
        queue_request(OP_UNLOAD, 16'hFFFE);     // frees slot 1
        queue_request(OP_LOAD,   16'h5555);     // lowest free slot reused
        queue_request(OP_LOAD,   16'h2AAA);     // full again
        queue_request(OP_UNLOAD, 16'h2AAA);     // unknown key
        queue_request(OP_UNLOAD, 16'h0103);
        queue_request(OP_LOAD,   16'h2AAA);
        wait_drained();

        // random over the whole key space, same limit
        gap_pct = 25;
        pick_hot_keys();
        queue_mixed(300, 55);
        wait_drained();

        // narrow limit: more distinct keys than slots, so the pool fills often
        gap_pct = 10;
        set_key_limit(16'd16);
        queue_mixed(200, 60);
        wait_drained();

        // zero limit rejects every key
        set_key_limit(16'd0);
        queue_mixed(30, 50);
        wait_drained();

        // only key 0 is valid: drive its pin count into saturation and back down
        gap_pct = 5;
        set_key_limit(16'd1);
        repeat (260) queue_request(OP_LOAD, 16'h0000);
        repeat (6) queue_request(OP_UNLOAD, 16'h0000);
        queue_mixed(60, 40);
        wait_drained();

        // random limit with heavy idling on both sides
        gap_pct = 30;
        set_key_limit(16'($urandom_range(2, 65534)));
        queue_mixed(250, 55);
        wait_drained();

        // back to the reset value, no idling at all in this last stretch
        gap_pct = 0;
        set_key_limit(16'd1024);
        queue_mixed(150, 50);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pool_results_due.size() != 0)
        begin
            errors++;
            $error("%0d results never arrived", pool_results_due.size());
        end
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/pps_pkg.sv
rtl/pps_cell.sv
rtl/pinned_slot_pool_top.sv
rtl/pps_check.sv
dv/tb.sv
